@@ hw/rtl/pump_pressure_switch_dry_run_assert.svh @@
// Assertion helpers for the pump pressure switch.
`ifndef PUMP_PRESSURE_SWITCH_DRY_RUN_ASSERT_SVH
`define PUMP_PRESSURE_SWITCH_DRY_RUN_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pump pressure switch check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pump pressure switch check failed");

`endif

@@ hw/rtl/pps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package pps_pkg;

    localparam int unsigned SAMPLE_W  = 10;
    localparam int unsigned SUM_W     = 14;   // ten 10-bit samples
    localparam int unsigned PRESS_W   = 8;
    localparam int unsigned TICK_W    = 16;

    // sum / 50 == (sum * 10486) >> 19 for every sum up to 10230
    localparam int unsigned PRESS_SHIFT = 19;
    localparam logic [SUM_W-1:0] PRESS_RECIP = 14'd10486;

    localparam logic [TICK_W-1:0] RETRY_UNIT      = 16'd600;
    localparam logic [TICK_W-1:0] RETRY_RUN_TICKS = 16'd200;
    localparam logic [PRESS_W-1:0] PRESS_MAX      = 8'd204;

    // Configuration register map
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LEVEL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LEVEL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRY_LEVEL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_PERIOD = 3'd3;

    localparam logic [5:0] HIGH_LEVEL_RST   = 6'd28;
    localparam logic [4:0] LOW_LEVEL_RST    = 5'd18;
    localparam logic [3:0] DRY_LEVEL_RST    = 4'd4;
    localparam logic [4:0] RETRY_PERIOD_RST = 5'd4;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_0;
        logic [SAMPLE_W-1:0] sample_1;
        logic [SAMPLE_W-1:0] sample_2;
        logic [SAMPLE_W-1:0] sample_3;
        logic [SAMPLE_W-1:0] sample_4;
        logic [SAMPLE_W-1:0] sample_5;
        logic [SAMPLE_W-1:0] sample_6;
        logic [SAMPLE_W-1:0] sample_7;
        logic [SAMPLE_W-1:0] sample_8;
        logic [SAMPLE_W-1:0] sample_9;
    } t_in;

    typedef struct packed {
        logic [PRESS_W-1:0] pressure;
        logic               pump_on;
        logic               dry_mode;
        logic               retry_active;
    } t_out;

    typedef struct packed {
        logic [5:0] high_level;
        logic [4:0] low_level;
        logic [3:0] dry_level;
        logic [4:0] retry_period;
    } t_cfg;

    typedef struct packed {
        logic pump_on;
        logic dry_mode;
        logic retry_active;
    } t_stat;

endpackage
`default_nettype wire

@@ hw/rtl/pump_pressure_switch_dry_run.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Pump pressure switch with dry-run protection. Each input transaction is a
// burst of ten 10-bit converter samples; each one yields exactly one result
// transaction carrying the pressure (sum / 50, tenths of a bar), the pump
// drive, the dry-mode flag and the retry flag, in input order. A transaction
// reaches result valid through the input register, then the result
// register; throughput is one transaction per cycle while the output side
// does not stall. The whole step - adder tree, reciprocal multiply for the
// divide by 50, and the dry/retry/hysteresis update - is one combinational
// pass between those two registers, and the controller state advances on
// the same edge as the result register loads. Input stall only rises when
// both registers are full and the output is stalled. The configuration port
// is always ready; write it only while no transaction is in flight. Index 0
// high_level, 1 low_level, 2 dry_level, 3 retry_period; other indexes are
// dropped, and data is truncated to each register's width.
module pump_pressure_switch_dry_run
    import pps_pkg::*;
(
    input  var logic                 i_clk,
    input  var logic                 i_rst_n,
    // input channel
    input  var logic                 i_valid,
    input  var t_in                  i_data,
    output logic                     o_stall,
    // result channel
    output logic                     o_valid,
    output t_out                     o_data,
    input  var logic                 i_stall,
    // configuration writes
    input  var logic                 i_cfg_valid,
    input  var logic [CFG_IDX_W-1:0] i_cfg_index,
    input  var logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                     o_cfg_ready
);

`include "pump_pressure_switch_dry_run_assert.svh"

    // ---------------- configuration registers ----------------
    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_level   <= HIGH_LEVEL_RST;
            r_cfg.low_level    <= LOW_LEVEL_RST;
            r_cfg.dry_level    <= DRY_LEVEL_RST;
            r_cfg.retry_period <= RETRY_PERIOD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_HIGH_LEVEL:   r_cfg.high_level   <= i_cfg_data[5:0];
                CFG_LOW_LEVEL:    r_cfg.low_level    <= i_cfg_data[4:0];
                CFG_DRY_LEVEL:    r_cfg.dry_level    <= i_cfg_data[3:0];
                CFG_RETRY_PERIOD: r_cfg.retry_period <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // advance: the result register is free, or its transaction leaves now
    logic r_in_valid;
    t_in  r_in;
    logic r_out_valid;
    t_out r_out;
    logic advance;
    logic in_accept;
    logic step;

    assign advance   = !r_out_valid || !i_stall;
    assign o_stall   = r_in_valid && !advance;
    assign in_accept = i_valid && !o_stall;
    assign step      = r_in_valid && advance;

    // input register (payload needs no reset)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_data;
        end
    end

    // ---------------- datapath ----------------
    logic [PRESS_W-1:0] pressure;
    t_stat              stat;

    pps_avg u_avg (
        .i_samples  (r_in),
        .o_pressure (pressure)
    );

    // controller state commits only when its result is captured
    pps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (step),
        .i_pressure (pressure),
        .i_cfg      (r_cfg),
        .o_stat     (stat)
    );

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out.pressure     <= pressure;
            r_out.pump_on      <= stat.pump_on;
            r_out.dry_mode     <= stat.dry_mode;
            r_out.retry_active <= stat.retry_active;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // ---------------- checks ----------------
    // a held input transaction is not lost while the output is blocked
    `PPS_ASSERT_NEXT(a_in_held, i_clk, i_rst_n, r_in_valid && !advance, r_in_valid)
    // divide by 50 never exceeds the full-scale result
    `PPS_ASSERT_NOW(a_press_range, i_clk, i_rst_n, r_out_valid, r_out.pressure <= PRESS_MAX)
    // outside dry mode a pressure below the low level always runs the pump
    `PPS_ASSERT_NOW(a_low_runs, i_clk, i_rst_n,
        r_out_valid && !r_out.dry_mode
            && (r_out.pressure < PRESS_W'(r_cfg.low_level)),
        r_out.pump_on)

endmodule
`default_nettype wire

@@ hw/rtl/pps_avg.sv @@
`timescale 1ns / 1ps
`default_nettype none
module pps_avg
    import pps_pkg::*;
(
    input  var t_in               i_samples,
    output logic [PRESS_W-1:0]    o_pressure
);

    logic [SUM_W-1:0]   sum;
    logic [2*SUM_W-1:0] prod;

    // adder tree over the ten samples
    always_comb begin
        sum = (SUM_W'(i_samples.sample_0) + SUM_W'(i_samples.sample_1))
            + (SUM_W'(i_samples.sample_2) + SUM_W'(i_samples.sample_3))
            + (SUM_W'(i_samples.sample_4) + SUM_W'(i_samples.sample_5))
            + (SUM_W'(i_samples.sample_6) + SUM_W'(i_samples.sample_7))
            + (SUM_W'(i_samples.sample_8) + SUM_W'(i_samples.sample_9));
        // divide by 50 through the reciprocal
        prod = (2*SUM_W)'(sum) * (2*SUM_W)'(PRESS_RECIP);
    end

    assign o_pressure = prod[PRESS_SHIFT +: PRESS_W];

endmodule
`default_nettype wire

@@ hw/rtl/pps_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module pps_ctrl
    import pps_pkg::*;
(
    input  var logic               i_clk,
    input  var logic               i_rst_n,
    input  var logic               i_en,
    input  var logic [PRESS_W-1:0] i_pressure,
    input  var t_cfg               i_cfg,
    output t_stat                  o_stat
);

    logic              r_drive;
    logic              r_dry;
    logic              r_retry;
    logic [TICK_W-1:0] r_ticks;

    logic              n_drive;
    logic              n_dry;
    logic              n_retry;
    logic [TICK_W-1:0] n_ticks;

    logic [TICK_W-1:0] tick_inc;
    logic [TICK_W-1:0] retry_limit;
    logic [PRESS_W-1:0] dry_lvl;

    always_comb begin
        dry_lvl     = PRESS_W'(i_cfg.dry_level);
        retry_limit = TICK_W'(i_cfg.retry_period) * RETRY_UNIT;
        tick_inc    = r_ticks + TICK_W'(1);

        n_drive = r_drive;
        n_dry   = r_dry;
        n_retry = r_retry;
        n_ticks = r_ticks;

        // dry detection; equal to the level keeps the flag
        if ((i_pressure < dry_lvl) && !r_dry) begin
            n_dry   = 1'b1;
            n_drive = 1'b0;
        end
        if (i_pressure > dry_lvl) begin
            n_dry = 1'b0;
        end

        // retry cycle, only advances while dry
        if (n_dry) begin
            n_ticks = tick_inc;
            if ((tick_inc > retry_limit) && !r_retry) begin
                n_drive = 1'b1;
                n_retry = 1'b1;
                n_ticks = '0;
            end else if ((tick_inc > RETRY_RUN_TICKS) && r_retry) begin
                n_drive = 1'b0;
                n_retry = 1'b0;
                n_ticks = '0;
            end
        end else begin
            // hysteresis, switch-on test first
            if (i_pressure < PRESS_W'(i_cfg.low_level)) begin
                n_drive = 1'b1;
            end else if (i_pressure > PRESS_W'(i_cfg.high_level)) begin
                n_drive = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive <= 1'b0;
            r_dry   <= 1'b0;
            r_retry <= 1'b0;
            r_ticks <= '0;
        end else if (i_en) begin
            r_drive <= n_drive;
            r_dry   <= n_dry;
            r_retry <= n_retry;
            r_ticks <= n_ticks;
        end
    end

    assign o_stat.pump_on      = n_drive;
    assign o_stat.dry_mode     = n_dry;
    assign o_stat.retry_active = n_retry;

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
    import pps_pkg::*;

    // Stimulus table: a row either writes a control register or offers one
    // sample burst. Rows flagged typed carry a hand-written reading; the
    // rest are checked against the pump switch predictor below.
    typedef enum bit {ROW_BURST, ROW_REG_WRITE} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
        t_in                   burst;
        bit                    typed;
        t_out                  reading;
    } t_row;

    // Pressure regimes used to shape the random bursts.
    typedef enum int {REGIME_DRY, REGIME_BAND, REGIME_EDGE, REGIME_RAW} t_regime;

    localparam int unsigned SAMPLES    = 10;
    localparam int          SAMPLE_MAX = 1023;
    localparam int          SUM_MAX    = 10230;
    localparam int          DIVISOR    = 50;

    // All block inputs start at known values.
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    t_in                   i_data      = '0;
    logic                  o_stall;
    logic                  o_valid;
    t_out                  o_data;
    logic                  i_stall     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_cfg_ready;

    // Predictor copy of the control registers and controller state.
    logic [5:0]  high_lvl;
    logic [4:0]  low_lvl;
    logic [3:0]  dry_lvl;
    logic [4:0]  period_lvl;
    logic        pump_drive;
    logic        dry_seen;
    logic        retry_run;
    logic [15:0] dry_tick_cnt;

    t_out awaited_readings[$];   // readings predicted for accepted bursts
    t_out want_reading;
    int   mismatches = 0;
    bit   calm       = 1'b0;     // no idling on either side once set

    pump_pressure_switch_dry_run dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (i_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // One controller step: average the burst, then dry-run detection, the
    // retry timer and finally the low/high hysteresis.
    function automatic t_out pump_switch_update(t_in burst);
        logic [SAMPLES*SAMPLE_W-1:0] flat;
        int                          total;
        int                          press;
        t_out                        reading;
        flat  = burst;
        total = 0;
        for (int k = 0; k < SAMPLES; k++) total += int'(flat[k*SAMPLE_W +: SAMPLE_W]);
        press = total / DIVISOR;

        if (press < int'(dry_lvl) && !dry_seen) begin
            dry_seen   = 1'b1;
            pump_drive = 1'b0;
        end
        // equal to the dry level leaves the flag alone
        if (press > int'(dry_lvl)) dry_seen = 1'b0;

        // retry timer only moves in dry mode; it survives leaving dry mode
        if (dry_seen) begin
            dry_tick_cnt = dry_tick_cnt + 16'd1;
            if (int'(dry_tick_cnt) > int'(period_lvl) * int'(RETRY_UNIT) && !retry_run) begin
                pump_drive   = 1'b1;
                retry_run    = 1'b1;
                dry_tick_cnt = '0;
            end else if (int'(dry_tick_cnt) > int'(RETRY_RUN_TICKS) && retry_run) begin
                pump_drive   = 1'b0;
                retry_run    = 1'b0;
                dry_tick_cnt = '0;
            end
        end

        // switch-on test first, so low above high still turns the pump on
        if (!dry_seen) begin
            if (press < int'(low_lvl)) pump_drive = 1'b1;
            else if (press > int'(high_lvl)) pump_drive = 1'b0;
        end

        reading.pressure     = 8'(press);
        reading.pump_on      = pump_drive;
        reading.dry_mode     = dry_seen;
        reading.retry_active = retry_run;
        return reading;
    endfunction

    function automatic t_out typed_reading(int press, bit pump, bit dry, bit retry);
        t_out reading;
        reading.pressure     = 8'(press);
        reading.pump_on      = pump;
        reading.dry_mode     = dry;
        reading.retry_active = retry;
        return reading;
    endfunction

    function automatic t_row burst_row(t_in burst, bit typed = 1'b0, t_out reading = '0);
        t_row row;
        row.kind      = ROW_BURST;
        row.reg_index = '0;
        row.reg_value = '0;
        row.burst     = burst;
        row.typed     = typed;
        row.reading   = reading;
        return row;
    endfunction

    function automatic t_row reg_row(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        t_row row;
        row.kind      = ROW_REG_WRITE;
        row.reg_index = index;
        row.reg_value = value;
        row.burst     = '0;
        row.typed     = 1'b0;
        row.reading   = '0;
        return row;
    endfunction

    // Burst whose average lands on the given pressure, samples spread
    // unevenly so the individual values still vary.
    function automatic t_in burst_at(int press);
        int                          sum;
        int                          i;
        int                          j;
        int                          room;
        int                          amount;
        int                          part [SAMPLES];
        logic [SAMPLES*SAMPLE_W-1:0] flat;
        if (press < 0) press = 0;
        if (press > int'(PRESS_MAX)) press = int'(PRESS_MAX);
        sum = press * DIVISOR + int'($urandom_range(0, DIVISOR - 1));
        if (sum > SUM_MAX) sum = SUM_MAX;
        for (int k = 0; k < SAMPLES; k++) part[k] = sum / SAMPLES + ((k < sum % SAMPLES) ? 1 : 0);
        for (int n = 0; n < 6; n++) begin
            i      = $urandom_range(0, SAMPLES - 1);
            j      = $urandom_range(0, SAMPLES - 1);
            room   = (part[i] < SAMPLE_MAX - part[j]) ? part[i] : SAMPLE_MAX - part[j];
            amount = $urandom_range(0, room);
            part[i] -= amount;
            part[j] += amount;
        end
        for (int k = 0; k < SAMPLES; k++) flat[k*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'(part[k]);
        return t_in'(flat);
    endfunction

    function automatic int pick_pressure(t_regime regime);
        int lo;
        int hi;
        lo = (low_lvl < high_lvl) ? int'(low_lvl) : int'(high_lvl);
        hi = (low_lvl < high_lvl) ? int'(high_lvl) : int'(low_lvl);
        case (regime)
            REGIME_DRY: begin
                return int'($urandom_range(0, int'(dry_lvl)));
            end
            REGIME_BAND: begin
                return $urandom_range((lo < 3) ? 0 : lo - 3, hi + 3);
            end
            default: begin
                case ($urandom_range(0, 2))
                    0: lo = int'(dry_lvl);
                    1: lo = int'(low_lvl);
                    default: lo = int'(high_lvl);
                endcase
                return lo + int'($urandom_range(0, 2)) - 1;
            end
        endcase
    endfunction

    // Hold the burst until the block takes it, then predict its reading.
    task automatic offer_burst(t_in burst, bit typed = 1'b0, t_out reading = '0);
        t_out predicted;
        i_valid <= 1'b1;
        i_data  <= burst;
        do @(posedge i_clk); while (o_stall);
        predicted = pump_switch_update(burst);
        awaited_readings.push_back(typed ? reading : predicted);
    endtask

    // Register writes only once every reading is out and the pipe has drained.
    task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        i_valid <= 1'b0;
        while (awaited_readings.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        // wider data is cut to each register's width; unknown indexes drop
        case (index)
            CFG_HIGH_LEVEL:   high_lvl   = value[5:0];
            CFG_LOW_LEVEL:    low_lvl    = value[4:0];
            CFG_DRY_LEVEL:    dry_lvl    = value[3:0];
            CFG_RETRY_PERIOD: period_lvl = value[4:0];
            default: ;
        endcase
    endtask

    task automatic set_levels(int high, int low, int dry, int period);
        write_register(CFG_HIGH_LEVEL, CFG_DATA_W'(high));
        write_register(CFG_LOW_LEVEL, CFG_DATA_W'(low));
        write_register(CFG_DRY_LEVEL, CFG_DATA_W'(dry));
        write_register(CFG_RETRY_PERIOD, CFG_DATA_W'(period));
    endtask

    // Random bursts in segments of one regime each; dry_weight is the
    // percentage of segments that hold the pressure at or below dry level.
    task automatic run_bursts(int count, int dry_weight);
        int                          left;
        int                          seg_len;
        t_regime                     regime;
        bit                          gappy;
        logic [SAMPLES*SAMPLE_W-1:0] raw;
        left = count;
        while (left > 0) begin
            if ($urandom_range(0, 99) < dry_weight) regime = REGIME_DRY;
            else begin
                case ($urandom_range(0, 2))
                    0: regime = REGIME_BAND;
                    1: regime = REGIME_EDGE;
                    default: regime = REGIME_RAW;
                endcase
            end
            seg_len = $urandom_range(1, 40);
            gappy   = !calm && ($urandom_range(0, 2) != 0);
            for (int n = 0; n < seg_len && left > 0; n++) begin
                if (regime == REGIME_RAW) begin
                    raw = (SAMPLES*SAMPLE_W)'({$urandom(), $urandom(), $urandom(), $urandom()});
                    offer_burst(t_in'(raw));
                end else begin
                    offer_burst(burst_at(pick_pressure(regime)));
                end
                left--;
                if (gappy && $urandom_range(0, 3) == 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                end
            end
        end
    endtask

    // Result side: stall bursts between ready stretches of mixed length, nothing
    // once calm is set.
    initial begin : result_backpressure
        forever begin
            if (calm) begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                case ($urandom_range(0, 5))
                    0, 1: begin
                        i_stall <= 1'b1;
                        repeat ($urandom_range(1, 3)) @(posedge i_clk);
                        // each stall burst ends with the result side ready again
                        i_stall <= 1'b0;
                        @(posedge i_clk);
                    end
                    2: begin
                        i_stall <= 1'b0;
                        repeat ($urandom_range(20, 60)) @(posedge i_clk);
                    end
                    default: begin
                        i_stall <= 1'b0;
                        repeat ($urandom_range(1, 4)) @(posedge i_clk);
                    end
                endcase
            end
        end
    end

    // Result checker: every accepted result transaction against the oldest
    // outstanding prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: p=%0d pump=%b dry=%b retry=%b",
                             o_data.pressure, o_data.pump_on, o_data.dry_mode,
                             o_data.retry_active);
            end else begin
                want_reading = awaited_readings.pop_front();
                if (o_data.pressure !== want_reading.pressure
                        || o_data.pump_on !== want_reading.pump_on
                        || o_data.dry_mode !== want_reading.dry_mode
                        || o_data.retry_active !== want_reading.retry_active) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: expected p=%0d pump=%b dry=%b retry=%b,",
                                  " got p=%0d pump=%b dry=%b retry=%b"},
                                 want_reading.pressure, want_reading.pump_on,
                                 want_reading.dry_mode, want_reading.retry_active,
                                 o_data.pressure, o_data.pump_on, o_data.dry_mode,
                                 o_data.retry_active);
                end
            end
        end
    end

    initial begin : stimulus
        t_row rows[$];

        high_lvl     = HIGH_LEVEL_RST;
        low_lvl      = LOW_LEVEL_RST;
        dry_lvl      = DRY_LEVEL_RST;
        period_lvl   = RETRY_PERIOD_RST;
        pump_drive   = 1'b0;
        dry_seen     = 1'b0;
        retry_run    = 1'b0;
        dry_tick_cnt = '0;

        // Directed part. Uniform bursts of value v give pressure v/5.
        // Out of reset: zero pressure enters dry mode, full scale leaves it.
        rows.push_back(burst_row(t_in'({10{10'd0}}), 1'b1,
                                 typed_reading(0, 1'b0, 1'b1, 1'b0)));
        rows.push_back(burst_row(t_in'({10{10'd1023}}), 1'b1,
                                 typed_reading(204, 1'b0, 1'b0, 1'b0)));
        // pressure on the dry level: flag untouched, below low level so on
        rows.push_back(burst_row(t_in'({10{10'd20}}), 1'b1,
                                 typed_reading(4, 1'b1, 1'b0, 1'b0)));
        // alternating bit patterns, well above high level
        rows.push_back(burst_row(t_in'({5{10'h2AA, 10'h155}}), 1'b1,
                                 typed_reading(102, 1'b0, 1'b0, 1'b0)));
        rows.push_back(burst_row(t_in'({5{10'h155, 10'h2AA}}), 1'b1,
                                 typed_reading(102, 1'b0, 1'b0, 1'b0)));
        rows.push_back(burst_row(t_in'({10{10'd15}})));   // dry again
        rows.push_back(burst_row(t_in'({10{10'd20}})));   // on dry level while dry
        rows.push_back(burst_row(t_in'({10{10'd85}})));   // just below low
        rows.push_back(burst_row(t_in'({10{10'd90}})));   // on low
        rows.push_back(burst_row(t_in'({10{10'd140}})));  // on high
        rows.push_back(burst_row(t_in'({10{10'd145}})));  // just above high
        rows.push_back(burst_row(t_in'({10{10'd90}})));
        rows.push_back(burst_row(t_in'({10{10'd85}})));
        // zero retry period: retry starts on the first dry tick
        rows.push_back(reg_row(CFG_RETRY_PERIOD, 6'd0));
        rows.push_back(burst_row(t_in'({10{10'd0}})));
        rows.push_back(burst_row(t_in'({10{10'd0}})));
        // low above high, over-wide data, a write to an unused index
        rows.push_back(reg_row(CFG_LOW_LEVEL, 6'h3F));
        rows.push_back(reg_row(CFG_HIGH_LEVEL, 6'd20));
        rows.push_back(reg_row(3'd5, 6'h3F));
        rows.push_back(reg_row(CFG_DRY_LEVEL, 6'h3F));
        rows.push_back(burst_row(t_in'({10{10'd50}})));
        rows.push_back(burst_row(t_in'({10{10'd125}})));
        rows.push_back(burst_row(t_in'({10{10'd150}})));
        rows.push_back(burst_row(t_in'({10{10'd1023}})));
        rows.push_back(reg_row(CFG_HIGH_LEVEL, 6'h3F));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[r]) begin
            if (rows[r].kind == ROW_REG_WRITE) write_register(rows[r].reg_index, rows[r].reg_value);
            else offer_burst(rows[r].burst, rows[r].typed, rows[r].reading);
        end

        // Random part. The retry timer carries across phases, so the short
        // periods sit in dry-heavy phases long enough to see retries.
        set_levels(28, 18, 4, 4);
        run_bursts(300, 25);
        set_levels(40, 25, 9, 0);
        run_bursts(350, 70);
        set_levels(20, 10, 9, 1);
        run_bursts(750, 90);
        set_levels(33, 12, 0, 20);
        calm = 1'b1;
        run_bursts(250, 30);

        i_valid <= 1'b0;
        while (awaited_readings.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #2_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

@@ pump_pressure_switch_dry_run.f @@
+incdir+hw/rtl
hw/rtl/pps_pkg.sv
hw/rtl/pps_avg.sv
hw/rtl/pps_ctrl.sv
hw/rtl/pump_pressure_switch_dry_run.sv
tb/tb_top.sv
